>>> design/assert_macros.svh
// Assertion macros shared by the register file RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion that is switched off while reset is held.
`define SCRF_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) else $error(msg);

// Concurrent assertion that is checked at every edge, reset included.
`define SCRF_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

>>> design/scrf_pkg.sv
// Types and constants of the system control register file.
package scrf_pkg;

    typedef struct packed {
        logic        cmd;
        logic [3:0]  crn;
        logic [2:0]  opc1;
        logic [3:0]  crm;
        logic [2:0]  opc2;
        logic [31:0] wdata;
    } t_req;

    typedef struct packed {
        logic [31:0] rdata;
        logic        accepted;
        logic        itlb_flush;
        logic        dtlb_flush;
        logic        icache_flush;
        logic        dcache_flush;
        logic        mmu_enabled;
        logic        high_vectors;
        logic [1:0]  fpu_access_level;
        logic        neon_enabled;
    } t_rsp;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_RESP
    } t_state;

    typedef struct packed {
        logic load;
        logic exec;
    } t_ctl;

    localparam logic CMD_READ  = 1'b0;
    localparam logic CMD_WRITE = 1'b1;

    localparam logic [3:0] CRN_ID    = 4'd0;
    localparam logic [3:0] CRN_CTRL  = 4'd1;
    localparam logic [3:0] CRN_TTB   = 4'd2;
    localparam logic [3:0] CRN_DOM   = 4'd3;
    localparam logic [3:0] CRN_FSR   = 4'd5;
    localparam logic [3:0] CRN_FAR   = 4'd6;
    localparam logic [3:0] CRN_CACHE = 4'd7;
    localparam logic [3:0] CRN_TLB   = 4'd8;
    localparam logic [3:0] CRN_REMAP = 4'd10;
    localparam logic [3:0] CRN_CTX   = 4'd13;

    localparam logic [1:0] FPU_NONE  = 2'd0;
    localparam logic [1:0] FPU_FULL  = 2'd1;
    localparam logic [1:0] FPU_OTHER = 2'd2;
    localparam logic [11:0] FPU_FULL_CODE = 12'h005;

    localparam logic [31:0] SCTL_RESET  = 32'h00c5_0078;
    localparam logic [31:0] SCTL_FORCE1 = 32'h00c5_0070;
    localparam logic [31:0] SCTL_KEEP   = 32'h7be7_7cff;
    localparam logic [31:0] DOM_RESET   = 32'hffff_ffff;

    localparam logic [31:0] ID_MAIN     = 32'h410f_c080;
    localparam logic [31:0] ID_CACHE    = 32'h8204_8004;
    localparam logic [31:0] CCSID_0     = 32'he007_e01a;
    localparam logic [31:0] CCSID_1     = 32'h2007_e01a;
    localparam logic [31:0] CCSID_2     = 32'hf000_0000;
    localparam logic [31:0] CLID        = 32'h0a00_0003;
    localparam logic [31:0] ID_PFR0     = 32'h0000_1031;
    localparam logic [31:0] ID_MEMF0    = 32'h3110_0003;
    localparam logic [31:0] ID_MEMF1    = 32'h2000_0000;
    localparam logic [31:0] ID_MEMF3    = 32'h0000_0011;
    localparam logic [31:0] ID_INSTF0   = 32'h0010_1111;
    localparam logic [31:0] ID_INSTF3   = 32'h1111_2131;

endpackage

>>> design/scrf_ctrl.sv
// Sequencer for the register file: accept, execute, present the result.
module scrf_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    output logic           o_valid,
    input  logic           i_ready,
    output scrf_pkg::t_ctl o_ctl
);

    scrf_pkg::t_state r_state;
    scrf_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= scrf_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            scrf_pkg::ST_IDLE: begin
                if (i_valid) begin
                    n_state = scrf_pkg::ST_EXEC;
                end
            end
            scrf_pkg::ST_EXEC: begin
                n_state = scrf_pkg::ST_RESP;
            end
            scrf_pkg::ST_RESP: begin
                if (i_ready) begin
                    n_state = scrf_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = scrf_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb begin
        o_ready    = 1'b0;
        o_valid    = 1'b0;
        o_ctl.load = 1'b0;
        o_ctl.exec = 1'b0;
        unique case (r_state)
            scrf_pkg::ST_IDLE: begin
                o_ready    = 1'b1;
                o_ctl.load = i_valid;
            end
            scrf_pkg::ST_EXEC: begin
                o_ctl.exec = 1'b1;
            end
            scrf_pkg::ST_RESP: begin
                o_valid = 1'b1;
            end
            default: begin
                o_ready = 1'b0;
            end
        endcase
    end

endmodule

>>> design/scrf_dpath.sv
// Register file datapath: access decode, system registers and result register.
module scrf_dpath (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  scrf_pkg::t_ctl i_ctl,
    input  scrf_pkg::t_req i_req,
    output scrf_pkg::t_rsp o_rsp
);

    scrf_pkg::t_req r_req;
    scrf_pkg::t_rsp r_rsp;

    logic [31:0] r_sctl;
    logic [31:0] r_aux;
    logic [31:0] r_acc;
    logic [31:0] r_ttb0;
    logic [31:0] r_ttb1;
    logic [31:0] r_ttbc;
    logic [31:0] r_dom;
    logic [31:0] r_cssel;
    logic [31:0] r_fault [4];
    logic [31:0] r_ctx   [4];
    logic [31:0] r_remap [2];

    logic [31:0] n_sctl;
    logic [31:0] n_acc;
    logic [11:0] fp_bits;

    logic        wr;
    logic        ok;
    logic [31:0] rd;
    logic        itlb;
    logic        dtlb;
    logic        ic;
    logic        dc;
    logic        we_sctl;
    logic        we_aux;
    logic        we_acc;
    logic        we_ttb0;
    logic        we_ttb1;
    logic        we_ttbc;
    logic        we_dom;
    logic        we_cssel;
    logic        we_fault;
    logic [1:0]  fault_idx;
    logic        we_ctx;
    logic [1:0]  ctx_idx;
    logic        we_remap;
    logic        remap_idx;

    // Read of the identification group; the top bit says whether it is defined.
    function automatic logic [32:0] id_read(
        input logic [2:0]  opc1,
        input logic [3:0]  crm,
        input logic [2:0]  opc2,
        input logic [31:0] cssel
    );
        logic [32:0] res;
        res = '0;
        if (crm == 4'd0 && opc1 == 3'd0) begin
            if (opc2 == 3'd0) begin
                res = {1'b1, scrf_pkg::ID_MAIN};
            end else if (opc2 == 3'd1) begin
                res = {1'b1, scrf_pkg::ID_CACHE};
            end else if (opc2 == 3'd2 || opc2 == 3'd3 || opc2 == 3'd5) begin
                res = {1'b1, 32'd0};
            end
        end else if (crm == 4'd0 && opc1 == 3'd1) begin
            if (opc2 == 3'd0) begin
                if (cssel == 32'd0) begin
                    res = {1'b1, scrf_pkg::CCSID_0};
                end else if (cssel == 32'd1) begin
                    res = {1'b1, scrf_pkg::CCSID_1};
                end else if (cssel == 32'd2) begin
                    res = {1'b1, scrf_pkg::CCSID_2};
                end else begin
                    res = {1'b1, 32'd0};
                end
            end else if (opc2 == 3'd1) begin
                res = {1'b1, scrf_pkg::CLID};
            end
        end else if (crm == 4'd0 && opc1 == 3'd2 && opc2 == 3'd0) begin
            res = {1'b1, cssel};
        end else if (crm == 4'd1 && opc1 == 3'd0) begin
            if (opc2 == 3'd0) begin
                res = {1'b1, scrf_pkg::ID_PFR0};
            end else if (opc2 == 3'd4) begin
                res = {1'b1, scrf_pkg::ID_MEMF0};
            end else if (opc2 == 3'd5) begin
                res = {1'b1, scrf_pkg::ID_MEMF1};
            end else if (opc2 == 3'd7) begin
                res = {1'b1, scrf_pkg::ID_MEMF3};
            end
        end else if (crm == 4'd2 && opc1 == 3'd0) begin
            if (opc2 == 3'd0) begin
                res = {1'b1, scrf_pkg::ID_INSTF0};
            end else if (opc2 == 3'd3) begin
                res = {1'b1, scrf_pkg::ID_INSTF3};
            end else if (opc2 == 3'd5) begin
                res = {1'b1, 32'd0};
            end
        end
        return res;
    endfunction

    assign wr = (r_req.cmd == scrf_pkg::CMD_WRITE);

    always_comb begin
        ok        = 1'b0;
        rd        = '0;
        itlb      = 1'b0;
        dtlb      = 1'b0;
        ic        = 1'b0;
        dc        = 1'b0;
        we_sctl   = 1'b0;
        we_aux    = 1'b0;
        we_acc    = 1'b0;
        we_ttb0   = 1'b0;
        we_ttb1   = 1'b0;
        we_ttbc   = 1'b0;
        we_dom    = 1'b0;
        we_cssel  = 1'b0;
        we_fault  = 1'b0;
        fault_idx = {1'b0, r_req.opc2[0]};
        we_ctx    = 1'b0;
        ctx_idx   = 2'(r_req.opc2 - 3'd1);
        we_remap  = 1'b0;
        remap_idx = r_req.opc2[0];
        unique case (r_req.crn)
            scrf_pkg::CRN_ID: begin
                if (!wr) begin
                    {ok, rd} = id_read(r_req.opc1, r_req.crm, r_req.opc2, r_cssel);
                end else if (r_req.crm == 4'd0 && r_req.opc1 == 3'd2
                             && r_req.opc2 == 3'd0) begin
                    we_cssel = 1'b1;
                    ok       = 1'b1;
                end
            end
            scrf_pkg::CRN_CTRL: begin
                if (r_req.crm == 4'd0) begin
                    if (r_req.opc2 == 3'd0) begin
                        we_sctl = wr;
                        rd      = r_sctl;
                        ok      = 1'b1;
                    end else if (r_req.opc2 == 3'd1) begin
                        we_aux = wr;
                        rd     = r_aux;
                        ok     = 1'b1;
                    end else if (r_req.opc2 == 3'd2) begin
                        we_acc = wr;
                        rd     = r_acc;
                        ok     = 1'b1;
                    end
                end
            end
            scrf_pkg::CRN_TTB: begin
                if (wr) begin
                    if (r_req.opc2 <= 3'd2) begin
                        we_ttb0 = (r_req.opc2 == 3'd0);
                        we_ttb1 = (r_req.opc2 == 3'd1);
                        we_ttbc = (r_req.opc2 == 3'd2);
                        itlb    = 1'b1;
                        dtlb    = 1'b1;
                        ok      = 1'b1;
                    end
                end else begin
                    // Every read of this group is defined; unknown fields read zero.
                    ok = 1'b1;
                    if (r_req.crm == 4'd0 && r_req.opc1 == 3'd0) begin
                        if (r_req.opc2 == 3'd0) begin
                            rd = r_ttb0;
                        end else if (r_req.opc2 == 3'd1) begin
                            rd = r_ttb1;
                        end else if (r_req.opc2 == 3'd2) begin
                            rd = r_ttbc;
                        end
                    end
                end
            end
            scrf_pkg::CRN_DOM: begin
                ok     = 1'b1;
                rd     = r_dom;
                we_dom = wr;
                if (wr && r_dom != r_req.wdata) begin
                    itlb = 1'b1;
                    dtlb = 1'b1;
                end
            end
            scrf_pkg::CRN_FSR: begin
                if (r_req.crm == 4'd0 && r_req.opc2 <= 3'd1) begin
                    we_fault = wr;
                    ok       = 1'b1;
                    rd       = r_fault[fault_idx];
                end
            end
            scrf_pkg::CRN_FAR: begin
                fault_idx = (r_req.opc2 == 3'd0) ? 2'd2 : 2'd3;
                if (r_req.opc2 == 3'd0 || r_req.opc2 == 3'd2) begin
                    we_fault = wr;
                    ok       = 1'b1;
                    rd       = r_fault[fault_idx];
                end
            end
            scrf_pkg::CRN_CACHE: begin
                if (wr && r_req.opc1 == 3'd0) begin
                    unique case (r_req.crm)
                        4'd1: begin
                            ic = (r_req.opc2 == 3'd0);
                            ok = (r_req.opc2 == 3'd0) || (r_req.opc2 == 3'd6);
                        end
                        4'd5: begin
                            ic = (r_req.opc2 == 3'd0) || (r_req.opc2 == 3'd1);
                            ok = (r_req.opc2 <= 3'd1) || (r_req.opc2 == 3'd4)
                                 || (r_req.opc2 == 3'd6) || (r_req.opc2 == 3'd7);
                        end
                        4'd6, 4'd14: begin
                            dc = (r_req.opc2 == 3'd1) || (r_req.opc2 == 3'd2);
                            ok = dc;
                        end
                        4'd10: begin
                            dc = (r_req.opc2 == 3'd1) || (r_req.opc2 == 3'd2);
                            ok = dc || (r_req.opc2 == 3'd4) || (r_req.opc2 == 3'd5);
                        end
                        4'd11: begin
                            dc = (r_req.opc2 == 3'd1);
                            ok = dc;
                        end
                        default: begin
                            ok = 1'b0;
                        end
                    endcase
                end
            end
            scrf_pkg::CRN_TLB: begin
                if (wr && r_req.opc2 <= 3'd2) begin
                    if (r_req.crm == 4'd3 || r_req.crm == 4'd7) begin
                        itlb = 1'b1;
                        dtlb = 1'b1;
                        ok   = 1'b1;
                    end else if (r_req.crm == 4'd5) begin
                        itlb = 1'b1;
                        ok   = 1'b1;
                    end else if (r_req.crm == 4'd6) begin
                        dtlb = 1'b1;
                        ok   = 1'b1;
                    end
                end
            end
            scrf_pkg::CRN_REMAP: begin
                if (r_req.crm == 4'd2 && r_req.opc1 == 3'd0 && r_req.opc2 <= 3'd1) begin
                    we_remap = wr;
                    ok       = 1'b1;
                    rd       = r_remap[remap_idx];
                end
            end
            scrf_pkg::CRN_CTX: begin
                if (r_req.opc1 == 3'd0 && r_req.crm == 4'd0
                    && r_req.opc2 >= 3'd1 && r_req.opc2 <= 3'd4) begin
                    we_ctx = wr;
                    ok     = 1'b1;
                    rd     = r_ctx[ctx_idx];
                    // Writing the context ID invalidates both TLBs.
                    if (wr && ctx_idx == 2'd0) begin
                        itlb = 1'b1;
                        dtlb = 1'b1;
                    end
                end
            end
            default: begin
                ok = 1'b0;
            end
        endcase
        if (!ok || wr) begin
            rd = '0;
        end
    end

    assign n_sctl  = we_sctl ? ((r_req.wdata | scrf_pkg::SCTL_FORCE1) & scrf_pkg::SCTL_KEEP)
                             : r_sctl;
    assign n_acc   = we_acc ? r_req.wdata : r_acc;
    assign fp_bits = n_acc[31:20];

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_req <= i_req;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sctl  <= scrf_pkg::SCTL_RESET;
            r_aux   <= '0;
            r_acc   <= '0;
            r_ttb0  <= '0;
            r_ttb1  <= '0;
            r_ttbc  <= '0;
            r_dom   <= scrf_pkg::DOM_RESET;
            r_cssel <= '0;
            for (int i = 0; i < 4; i++) begin
                r_fault[i] <= '0;
                r_ctx[i]   <= '0;
            end
            for (int i = 0; i < 2; i++) begin
                r_remap[i] <= '0;
            end
        end else if (i_ctl.exec) begin
            r_sctl <= n_sctl;
            r_acc  <= n_acc;
            if (we_aux) begin
                r_aux <= r_req.wdata;
            end
            if (we_ttb0) begin
                r_ttb0 <= r_req.wdata;
            end
            if (we_ttb1) begin
                r_ttb1 <= r_req.wdata;
            end
            if (we_ttbc) begin
                r_ttbc <= r_req.wdata;
            end
            if (we_dom) begin
                r_dom <= r_req.wdata;
            end
            if (we_cssel) begin
                r_cssel <= r_req.wdata;
            end
            if (we_fault) begin
                r_fault[fault_idx] <= r_req.wdata;
            end
            if (we_ctx) begin
                r_ctx[ctx_idx] <= r_req.wdata;
            end
            if (we_remap) begin
                r_remap[remap_idx] <= r_req.wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.exec) begin
            r_rsp.rdata        <= rd;
            r_rsp.accepted     <= ok;
            r_rsp.itlb_flush   <= itlb;
            r_rsp.dtlb_flush   <= dtlb;
            r_rsp.icache_flush <= ic;
            r_rsp.dcache_flush <= dc;
            r_rsp.mmu_enabled  <= n_sctl[0];
            r_rsp.high_vectors <= n_sctl[13];
            if (fp_bits == 12'd0) begin
                r_rsp.fpu_access_level <= scrf_pkg::FPU_NONE;
            end else if (fp_bits == scrf_pkg::FPU_FULL_CODE) begin
                r_rsp.fpu_access_level <= scrf_pkg::FPU_FULL;
            end else begin
                r_rsp.fpu_access_level <= scrf_pkg::FPU_OTHER;
            end
            r_rsp.neon_enabled <= ~n_acc[31];
        end
    end

    assign o_rsp = r_rsp;

endmodule

>>> design/system_control_register_file_top.sv
// Top level of the system control register file.
//
// One coprocessor access enters per beat on the request channel (i_valid,
// o_ready, i_req) and one result leaves per beat on the response channel
// (o_valid, i_ready, o_rsp). The result carries read data, the accepted
// flag, single-beat flush requests for the TLBs and caches, and the MMU,
// vector, FPU and NEON status as they stand after the access.
// An accepted request is decoded and executed in the next cycle, and its
// result is presented from the cycle after that.
// A three-state sequencer handles one access at a time, so a new request can
// be taken no earlier than the cycle after the response beat completes.
// While the receiver holds i_ready low the result stays registered and
// o_ready stays low. Synchronous reset loads every system register with its
// architectural reset value at once and returns the sequencer to idle.
`include "assert_macros.svh"

module system_control_register_file_top (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  scrf_pkg::t_req i_req,
    output logic           o_valid,
    input  logic           i_ready,
    output scrf_pkg::t_rsp o_rsp
);

    scrf_pkg::t_ctl ctl;
    logic           req_beat;
    logic           undef_flush;

    scrf_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_ctl   (ctl)
    );

    scrf_dpath u_dpath (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (ctl),
        .i_req   (i_req),
        .o_rsp   (o_rsp)
    );

    assign req_beat    = i_valid && o_ready;
    assign undef_flush = o_valid && !o_rsp.accepted
                         && (o_rsp.itlb_flush || o_rsp.dtlb_flush
                             || o_rsp.icache_flush || o_rsp.dcache_flush);

    // A request is never taken while a result is still waiting.
    `SCRF_ASSERT(a_no_overlap, i_clk, i_rst_n, !(o_valid && o_ready), "ready while busy")

    // After a request beat the sequencer stops taking requests.
    `SCRF_ASSERT(a_one_at_a_time, i_clk, i_rst_n, req_beat |=> !o_ready, "second request taken")

    // An undefined access must not raise any flush request.
    `SCRF_ASSERT(a_undef_quiet, i_clk, i_rst_n, !undef_flush, "flush on undefined access")

    // Reset leaves the sequencer idle in the next cycle.
    `SCRF_ASSERT_ALWAYS(a_reset_idle, i_clk, !i_rst_n |=> (o_ready && !o_valid), "not idle")

endmodule

>>> verif/tb_system_control_register_file_top.sv
// Self-checking testbench for the system control register file.
`timescale 1ns / 1ps

module tb_system_control_register_file_top;

    localparam int unsigned RANDOM_ACCESSES = 900;
    localparam int unsigned QUIET_LIMIT     = 2000;
    localparam int unsigned TAIL_CYCLES     = 8;
    localparam logic [3:0]  CRN_UNUSED      = 4'd15;

    typedef struct {
        scrf_pkg::t_req req;
        bit             drain;
    } t_pending_access;

    logic           i_clk;
    logic           i_rst_n = 1'b0;
    logic           i_valid = 1'b0;
    logic           o_ready;
    scrf_pkg::t_req i_req = '0;
    logic           o_valid;
    logic           i_ready = 1'b0;
    scrf_pkg::t_rsp o_rsp;

    t_pending_access pending_access_q[$];
    scrf_pkg::t_rsp  expected_rsp_q[$];

    // Shadow copy of the register file.
    logic [31:0] m_sctl, m_actlr, m_cpacr, m_ttbr0, m_ttbr1, m_ttbcr, m_dacr, m_csselr;
    logic [31:0] m_fault[4];
    logic [31:0] m_ctx[4];
    logic [31:0] m_remap[2];

    int unsigned req_beats, rsp_beats, read_beats, write_beats;
    int unsigned undefined_count, flush_count, field_errors;
    int unsigned total_accesses;
    int unsigned quiet_cycles;
    bit          calm;

    system_control_register_file_top DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_req   (i_req),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_rsp   (o_rsp)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // No idling on either side for a stretch in the middle of the run.
    assign calm = (req_beats >= 300) && (req_beats < 420);

    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 45) return 0;
        if (r < 80) return $urandom_range(1, 3);
        if (r < 95) return $urandom_range(4, 10);
        return $urandom_range(20, 50);
    endfunction

    function automatic scrf_pkg::t_rsp predict_access(scrf_pkg::t_req r);
        scrf_pkg::t_rsp o;
        logic [31:0]    rd;
        logic [11:0]    fp;
        logic           wr, ok, itlb, dtlb, ic, dc;
        rd   = '0;
        ok   = 1'b0;
        itlb = 1'b0;
        dtlb = 1'b0;
        ic   = 1'b0;
        dc   = 1'b0;
        wr   = (r.cmd == scrf_pkg::CMD_WRITE);
        case (r.crn)
            scrf_pkg::CRN_ID: begin
                if (wr) begin
                    if (r.crm == 0 && r.opc1 == 2 && r.opc2 == 0) begin
                        m_csselr = r.wdata;
                        ok = 1'b1;
                    end
                end else begin
                    ok = 1'b1;
                    case ({r.opc1, r.crm, r.opc2})
                        {3'd0, 4'd0, 3'd0}: rd = scrf_pkg::ID_MAIN;
                        {3'd0, 4'd0, 3'd1}: rd = scrf_pkg::ID_CACHE;
                        {3'd0, 4'd0, 3'd2},
                        {3'd0, 4'd0, 3'd3},
                        {3'd0, 4'd0, 3'd5}: rd = '0;
                        {3'd1, 4'd0, 3'd0}: begin
                            if (m_csselr == 0) rd = scrf_pkg::CCSID_0;
                            else if (m_csselr == 1) rd = scrf_pkg::CCSID_1;
                            else if (m_csselr == 2) rd = scrf_pkg::CCSID_2;
                            else rd = '0;
                        end
                        {3'd1, 4'd0, 3'd1}: rd = scrf_pkg::CLID;
                        {3'd2, 4'd0, 3'd0}: rd = m_csselr;
                        {3'd0, 4'd1, 3'd0}: rd = scrf_pkg::ID_PFR0;
                        {3'd0, 4'd1, 3'd4}: rd = scrf_pkg::ID_MEMF0;
                        {3'd0, 4'd1, 3'd5}: rd = scrf_pkg::ID_MEMF1;
                        {3'd0, 4'd1, 3'd7}: rd = scrf_pkg::ID_MEMF3;
                        {3'd0, 4'd2, 3'd0}: rd = scrf_pkg::ID_INSTF0;
                        {3'd0, 4'd2, 3'd3}: rd = scrf_pkg::ID_INSTF3;
                        {3'd0, 4'd2, 3'd5}: rd = '0;
                        default: ok = 1'b0;
                    endcase
                end
            end
            scrf_pkg::CRN_CTRL: begin
                if (r.crm == 0) begin
                    ok = (r.opc2 <= 2);
                    case (r.opc2)
                        3'd0: if (wr) m_sctl = (r.wdata | scrf_pkg::SCTL_FORCE1)
                                               & scrf_pkg::SCTL_KEEP;
                              else rd = m_sctl;
                        3'd1: if (wr) m_actlr = r.wdata; else rd = m_actlr;
                        3'd2: if (wr) m_cpacr = r.wdata; else rd = m_cpacr;
                        default: ;
                    endcase
                end
            end
            scrf_pkg::CRN_TTB: begin
                if (wr) begin
                    if (r.opc2 <= 2) begin
                        if (r.opc2 == 0) m_ttbr0 = r.wdata;
                        else if (r.opc2 == 1) m_ttbr1 = r.wdata;
                        else m_ttbcr = r.wdata;
                        itlb = 1'b1;
                        dtlb = 1'b1;
                        ok   = 1'b1;
                    end
                end else begin
                    // Reads that match no base register are still accepted.
                    ok = 1'b1;
                    if (r.crm == 0 && r.opc1 == 0) begin
                        if (r.opc2 == 0) rd = m_ttbr0;
                        else if (r.opc2 == 1) rd = m_ttbr1;
                        else if (r.opc2 == 2) rd = m_ttbcr;
                    end
                end
            end
            scrf_pkg::CRN_DOM: begin
                if (wr) begin
                    if (m_dacr != r.wdata) begin
                        itlb = 1'b1;
                        dtlb = 1'b1;
                    end
                    m_dacr = r.wdata;
                end else begin
                    rd = m_dacr;
                end
                ok = 1'b1;
            end
            scrf_pkg::CRN_FSR: begin
                if (r.crm == 0 && r.opc2 <= 1) begin
                    if (wr) m_fault[{1'b0, r.opc2[0]}] = r.wdata;
                    else rd = m_fault[{1'b0, r.opc2[0]}];
                    ok = 1'b1;
                end
            end
            scrf_pkg::CRN_FAR: begin
                if (r.opc2 == 0 || r.opc2 == 2) begin
                    if (wr) m_fault[{1'b1, r.opc2[1]}] = r.wdata;
                    else rd = m_fault[{1'b1, r.opc2[1]}];
                    ok = 1'b1;
                end
            end
            scrf_pkg::CRN_CACHE: begin
                if (wr && r.opc1 == 0) begin
                    case (r.crm)
                        4'd1: begin
                            ic = (r.opc2 == 0);
                            ok = (r.opc2 == 0 || r.opc2 == 6);
                        end
                        4'd5: begin
                            ic = (r.opc2 <= 1);
                            ok = (r.opc2 <= 1 || r.opc2 == 4 || r.opc2 == 6 || r.opc2 == 7);
                        end
                        4'd6, 4'd14: begin
                            dc = (r.opc2 == 1 || r.opc2 == 2);
                            ok = dc;
                        end
                        4'd10: begin
                            dc = (r.opc2 == 1 || r.opc2 == 2);
                            ok = dc || r.opc2 == 4 || r.opc2 == 5;
                        end
                        4'd11: begin
                            dc = (r.opc2 == 1);
                            ok = dc;
                        end
                        default: ;
                    endcase
                end
            end
            scrf_pkg::CRN_TLB: begin
                if (wr && r.opc2 <= 2) begin
                    itlb = (r.crm == 3 || r.crm == 7 || r.crm == 5);
                    dtlb = (r.crm == 3 || r.crm == 7 || r.crm == 6);
                    ok   = itlb || dtlb;
                end
            end
            scrf_pkg::CRN_REMAP: begin
                if (r.crm == 2 && r.opc1 == 0 && r.opc2 <= 1) begin
                    if (wr) m_remap[r.opc2[0]] = r.wdata; else rd = m_remap[r.opc2[0]];
                    ok = 1'b1;
                end
            end
            scrf_pkg::CRN_CTX: begin
                if (r.opc1 == 0 && r.crm == 0 && r.opc2 >= 1 && r.opc2 <= 4) begin
                    if (wr) begin
                        m_ctx[2'(r.opc2 - 3'd1)] = r.wdata;
                        // A new context ID invalidates both TLBs.
                        if (r.opc2 == 1) begin
                            itlb = 1'b1;
                            dtlb = 1'b1;
                        end
                    end else begin
                        rd = m_ctx[2'(r.opc2 - 3'd1)];
                    end
                    ok = 1'b1;
                end
            end
            default: ;
        endcase
        if (!ok || wr) rd = '0;
        fp = m_cpacr[31:20];
        o.rdata            = rd;
        o.accepted         = ok;
        o.itlb_flush       = itlb;
        o.dtlb_flush       = dtlb;
        o.icache_flush     = ic;
        o.dcache_flush     = dc;
        o.mmu_enabled      = m_sctl[0];
        o.high_vectors     = m_sctl[13];
        if (fp == 12'd0) o.fpu_access_level = scrf_pkg::FPU_NONE;
        else if (fp == scrf_pkg::FPU_FULL_CODE) o.fpu_access_level = scrf_pkg::FPU_FULL;
        else o.fpu_access_level = scrf_pkg::FPU_OTHER;
        o.neon_enabled     = ~m_cpacr[31];
        return o;
    endfunction

    function automatic scrf_pkg::t_req random_access();
        scrf_pkg::t_req r;
        int unsigned    sel;
        int unsigned    cache_crm[6] = '{1, 5, 6, 10, 11, 14};
        r.cmd  = 1'($urandom_range(0, 1));
        r.crn  = 4'($urandom_range(0, 15));
        r.opc1 = 3'($urandom_range(0, 7));
        r.crm  = 4'($urandom_range(0, 15));
        r.opc2 = 3'($urandom_range(0, 7));
        sel = $urandom_range(0, 99);
        if (sel < 10) r.wdata = '0;
        else if (sel < 20) r.wdata = '1;
        else if (sel < 30) r.wdata = {scrf_pkg::FPU_FULL_CODE, 20'($urandom)};
        else if (sel < 40) r.wdata = 32'($urandom_range(0, 3));
        else r.wdata = $urandom;
        // Most accesses land on a defined register; the rest stay as noise.
        if ($urandom_range(0, 99) < 60) begin
            case ($urandom_range(0, 9))
                0: begin
                    r.crn  = scrf_pkg::CRN_ID;
                    r.opc1 = 3'($urandom_range(0, 2));
                    r.crm  = 4'($urandom_range(0, 2));
                end
                1: begin
                    r.crn  = scrf_pkg::CRN_CTRL;
                    r.crm  = 4'd0;
                    r.opc2 = 3'($urandom_range(0, 2));
                end
                2: begin
                    r.crn  = scrf_pkg::CRN_TTB;
                    r.opc1 = 3'd0;
                    r.crm  = 4'd0;
                    r.opc2 = 3'($urandom_range(0, 3));
                end
                3: r.crn = scrf_pkg::CRN_DOM;
                4: begin
                    r.crn  = scrf_pkg::CRN_FSR;
                    r.crm  = 4'd0;
                    r.opc2 = 3'($urandom_range(0, 1));
                end
                5: begin
                    r.crn  = scrf_pkg::CRN_FAR;
                    r.opc2 = {1'b0, 1'($urandom_range(0, 1)), 1'b0};
                end
                6: begin
                    r.crn  = scrf_pkg::CRN_CACHE;
                    r.cmd  = scrf_pkg::CMD_WRITE;
                    r.opc1 = 3'd0;
                    r.crm  = 4'(cache_crm[$urandom_range(0, 5)]);
                end
                7: begin
                    r.crn  = scrf_pkg::CRN_TLB;
                    r.cmd  = scrf_pkg::CMD_WRITE;
                    r.crm  = 4'($urandom_range(3, 7));
                    r.opc2 = 3'($urandom_range(0, 2));
                end
                8: begin
                    r.crn  = scrf_pkg::CRN_REMAP;
                    r.opc1 = 3'd0;
                    r.crm  = 4'd2;
                    r.opc2 = 3'($urandom_range(0, 1));
                end
                default: begin
                    r.crn  = scrf_pkg::CRN_CTX;
                    r.opc1 = 3'd0;
                    r.crm  = 4'd0;
                    r.opc2 = 3'($urandom_range(1, 4));
                end
            endcase
        end
        return r;
    endfunction

    task automatic add_access(logic cmd, logic [3:0] crn, logic [2:0] opc1, logic [3:0] crm,
                              logic [2:0] opc2, logic [31:0] wdata, bit drain);
        t_pending_access p;
        p.req   = '{cmd: cmd, crn: crn, opc1: opc1, crm: crm, opc2: opc2, wdata: wdata};
        p.drain = drain;
        pending_access_q.push_back(p);
    endtask

    task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
        if (got !== want) begin
            $display("%0t: %s expected %h got %h", $time, name, want, got);
            field_errors++;
        end
    endtask

    // Request side: presents queued accesses with random gaps.
    always @(posedge i_clk) begin : driver
        int unsigned     gap_left;
        t_pending_access p;
        if (!i_rst_n) begin
            i_valid  <= 1'b0;
            gap_left = 0;
        end else if (!i_valid || o_ready) begin
            if (gap_left > 0) begin
                gap_left--;
                i_valid <= 1'b0;
            end else if (pending_access_q.size() != 0 &&
                         !(pending_access_q[0].drain && (i_valid || expected_rsp_q.size() != 0)))
            begin
                p = pending_access_q.pop_front();
                i_req    <= p.req;
                i_valid  <= 1'b1;
                gap_left = calm ? 0 : pick_gap();
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // Response side: random back-pressure, prediction and checking.
    always @(posedge i_clk) begin : monitor
        int unsigned    stall_left;
        scrf_pkg::t_rsp want;
        if (!i_rst_n) begin
            i_ready    <= 1'b0;
            stall_left = 0;
        end else begin
            if (o_valid && i_ready) begin
                rsp_beats++;
                if (expected_rsp_q.size() == 0) begin
                    $display("%0t: result beat with nothing expected, got %h", $time, o_rsp);
                    field_errors++;
                end else begin
                    want = expected_rsp_q.pop_front();
                    check_field("rdata", want.rdata, o_rsp.rdata);
                    check_field("accepted", 32'(want.accepted), 32'(o_rsp.accepted));
                    check_field("itlb_flush", 32'(want.itlb_flush), 32'(o_rsp.itlb_flush));
                    check_field("dtlb_flush", 32'(want.dtlb_flush), 32'(o_rsp.dtlb_flush));
                    check_field("icache_flush", 32'(want.icache_flush),
                                32'(o_rsp.icache_flush));
                    check_field("dcache_flush", 32'(want.dcache_flush),
                                32'(o_rsp.dcache_flush));
                    check_field("mmu_enabled", 32'(want.mmu_enabled), 32'(o_rsp.mmu_enabled));
                    check_field("high_vectors", 32'(want.high_vectors),
                                32'(o_rsp.high_vectors));
                    check_field("fpu_access_level", 32'(want.fpu_access_level),
                                32'(o_rsp.fpu_access_level));
                    check_field("neon_enabled", 32'(want.neon_enabled),
                                32'(o_rsp.neon_enabled));
                end
            end
            if (i_valid && o_ready) begin
                req_beats++;
                if (i_req.cmd == scrf_pkg::CMD_WRITE) write_beats++; else read_beats++;
                want = predict_access(i_req);
                if (!want.accepted) undefined_count++;
                if (want.itlb_flush || want.dtlb_flush || want.icache_flush || want.dcache_flush)
                    flush_count++;
                expected_rsp_q.push_back(want);
            end
            if (stall_left > 0) begin
                stall_left--;
                i_ready <= 1'b0;
            end else begin
                i_ready <= 1'b1;
                stall_left = calm ? 0 : pick_gap();
            end
        end
    end

    always @(posedge i_clk) begin : watchdog
        if (!i_rst_n || (i_valid && o_ready) || (o_valid && i_ready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
            if (quiet_cycles == QUIET_LIMIT) begin
                $display("%0t: no beat for %0d cycles", $time, QUIET_LIMIT);
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
        end
    end

    initial begin
        m_sctl   = scrf_pkg::SCTL_RESET;
        m_actlr  = '0;
        m_cpacr  = '0;
        m_ttbr0  = '0;
        m_ttbr1  = '0;
        m_ttbcr  = '0;
        m_dacr   = scrf_pkg::DOM_RESET;
        m_csselr = '0;
        for (int i = 0; i < 4; i++) begin
            m_fault[i] = '0;
            m_ctx[i]   = '0;
        end
        m_remap[0] = '0;
        m_remap[1] = '0;

        // Directed accesses: ID words, cache size selection out of range, forced
        // control bits, FPU and NEON levels, flush sources and undefined space.
        add_access(scrf_pkg::CMD_READ,  scrf_pkg::CRN_ID,    3'd0, 4'd0,  3'd0, '0, 1'b0);
        add_access(scrf_pkg::CMD_WRITE, scrf_pkg::CRN_ID,    3'd2, 4'd0,  3'd0, 32'd2, 1'b0);
        add_access(scrf_pkg::CMD_READ,  scrf_pkg::CRN_ID,    3'd1, 4'd0,  3'd0, '0, 1'b0);
        add_access(scrf_pkg::CMD_WRITE, scrf_pkg::CRN_ID,    3'd2, 4'd0,  3'd0, '1, 1'b0);
        add_access(scrf_pkg::CMD_READ,  scrf_pkg::CRN_ID,    3'd1, 4'd0,  3'd0, '0, 1'b0);
        add_access(scrf_pkg::CMD_READ,  scrf_pkg::CRN_ID,    3'd2, 4'd0,  3'd0, '0, 1'b0);
        add_access(scrf_pkg::CMD_WRITE, scrf_pkg::CRN_CTRL,  3'd0, 4'd0,  3'd0, '1, 1'b0);
        add_access(scrf_pkg::CMD_READ,  scrf_pkg::CRN_CTRL,  3'd7, 4'd0,  3'd0, '0, 1'b0);
        add_access(scrf_pkg::CMD_WRITE, scrf_pkg::CRN_CTRL,  3'd0, 4'd0,  3'd0, '0, 1'b0);
        add_access(scrf_pkg::CMD_WRITE, scrf_pkg::CRN_CTRL,  3'd0, 4'd0,  3'd2,
                   32'h0050_0000, 1'b0);
        add_access(scrf_pkg::CMD_WRITE, scrf_pkg::CRN_CTRL,  3'd0, 4'd0,  3'd2,
                   32'hfff0_0000, 1'b0);
        add_access(scrf_pkg::CMD_READ,  scrf_pkg::CRN_CTRL,  3'd0, 4'd0,  3'd2, '0, 1'b0);
        add_access(scrf_pkg::CMD_WRITE, scrf_pkg::CRN_TTB,   3'd0, 4'd0,  3'd0, '1, 1'b0);
        add_access(scrf_pkg::CMD_WRITE, scrf_pkg::CRN_TTB,   3'd0, 4'd0,  3'd3, '1, 1'b0);
        add_access(scrf_pkg::CMD_READ,  scrf_pkg::CRN_TTB,   3'd0, 4'd0,  3'd5, '0, 1'b0);
        add_access(scrf_pkg::CMD_READ,  scrf_pkg::CRN_TTB,   3'd0, 4'd0,  3'd0, '0, 1'b0);
        add_access(scrf_pkg::CMD_WRITE, scrf_pkg::CRN_DOM,   3'd0, 4'd0,  3'd0,
                   scrf_pkg::DOM_RESET, 1'b0);
        add_access(scrf_pkg::CMD_WRITE, scrf_pkg::CRN_DOM,   3'd0, 4'd0,  3'd0, '0, 1'b0);
        add_access(scrf_pkg::CMD_WRITE, scrf_pkg::CRN_CACHE, 3'd0, 4'd5,  3'd0, '0, 1'b0);
        add_access(scrf_pkg::CMD_WRITE, scrf_pkg::CRN_CACHE, 3'd0, 4'd14, 3'd2, '0, 1'b0);
        add_access(scrf_pkg::CMD_WRITE, scrf_pkg::CRN_TLB,   3'd0, 4'd7,  3'd2, '0, 1'b0);
        add_access(scrf_pkg::CMD_WRITE, scrf_pkg::CRN_TLB,   3'd0, 4'd6,  3'd0, '0, 1'b0);
        add_access(scrf_pkg::CMD_WRITE, scrf_pkg::CRN_REMAP, 3'd0, 4'd2,  3'd1,
                   32'ha5a5_5a5a, 1'b0);
        add_access(scrf_pkg::CMD_READ,  scrf_pkg::CRN_REMAP, 3'd0, 4'd2,  3'd1, '0, 1'b0);
        add_access(scrf_pkg::CMD_WRITE, scrf_pkg::CRN_CTX,   3'd0, 4'd0,  3'd1, '1, 1'b0);
        add_access(scrf_pkg::CMD_READ,  CRN_UNUSED,          3'd7, 4'd15, 3'd7, '1, 1'b1);
        for (int i = 0; i < RANDOM_ACCESSES; i++) begin
            t_pending_access p;
            p.req   = random_access();
            p.drain = (i % 150 == 149);
            pending_access_q.push_back(p);
        end
        total_accesses = pending_access_q.size();

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (req_beats < total_accesses) @(posedge i_clk);
        while (expected_rsp_q.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("Covered %0d accesses (%0d reads, %0d writes), %0d undefined, %0d with flushes.",
                 req_beats, read_beats, write_beats, undefined_count, flush_count);
        $display("Checked %0d result beats, %0d field errors.", rsp_beats, field_errors);
        if (field_errors == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

>>> sim.f
+incdir+design
design/scrf_pkg.sv
design/scrf_ctrl.sv
design/scrf_dpath.sv
design/system_control_register_file_top.sv
verif/tb_system_control_register_file_top.sv
